>>> hdl/sraa_pkg.sv
// Shared types, sizes, request and status codes for the sensor running average alarm.
// Used by every module of the block; it depends on nothing else.
package sraa_pkg;

  // Table and window sizes.
  localparam int TABLE_ENTRIES = 32;
  localparam int AVG_LEN       = 5;

  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W  = $clog2(AVG_LEN + 1);
  localparam int SUM_W   = 16 + $clog2(AVG_LEN);
  localparam int MAG_W   = SUM_W;

  // Reciprocal divide: quotient estimate is (mag * floor(2^17 / d)) >> 17.
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = MAG_W + RECIP_W;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request types.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MEAS = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_MEASURED = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_LOADED   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Configuration register indexes.
  localparam logic REG_HOT  = 1'b0;
  localparam logic REG_COLD = 1'b1;

  localparam logic signed [15:0] HOT_RESET  = 16'sd2500;
  localparam logic signed [15:0] COLD_RESET = 16'sd1000;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        sensor;
    logic [15:0]        room_id;
    logic signed [15:0] sample_value;
    logic [31:0]        sample_time;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        room_out;
    logic signed [15:0] average;
    logic               hot;
    logic               cold;
    logic [31:0]        time_out;
  } result_t;

  // Classified request as it sits in the queue.
  typedef struct packed {
    logic               op;
    logic [15:0]        sensor;
    logic [15:0]        room_id;
    logic signed [15:0] sample_value;
    logic [31:0]        sample_time;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One table row kept in memory.
  typedef struct packed {
    logic [15:0]                room;
    logic                       full;
    logic [FILL_W-1:0]          fill;
    logic [AVG_LEN-1:0][15:0]   samples;
  } row_t;

  // floor(2^17 / d) for divisors 1 to 16.
  function automatic logic [RECIP_W-1:0] recip(input logic [4:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      5'd1:    r = 18'd131072;
      5'd2:    r = 18'd65536;
      5'd3:    r = 18'd43690;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd26214;
      5'd6:    r = 18'd21845;
      5'd7:    r = 18'd18724;
      5'd8:    r = 18'd16384;
      5'd9:    r = 18'd14563;
      5'd10:   r = 18'd13107;
      5'd11:   r = 18'd11915;
      5'd12:   r = 18'd10922;
      5'd13:   r = 18'd10082;
      5'd14:   r = 18'd9362;
      5'd15:   r = 18'd8738;
      5'd16:   r = 18'd8192;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/sraa_front.sv
// Front stage: takes requests from the input channel, classifies them and pushes them
// into the queue. Depends on sraa_pkg.
module sraa_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sraa_pkg::item_t   item,
  input  sraa_pkg::qstat_t  qstat,
  output logic              push,
  output sraa_pkg::cmd_t    push_cmd
);

  logic           held;
  sraa_pkg::cmd_t held_cmd;
  sraa_pkg::cmd_t cls_cmd;

  // Classify: keep only the fields that the request type uses.
  always_comb begin
    cls_cmd        = '0;
    cls_cmd.op     = item.req_type;
    cls_cmd.sensor = item.sensor;
    if (item.req_type == sraa_pkg::REQ_LOAD) begin
      cls_cmd.room_id = item.room_id;
    end else begin
      cls_cmd.sample_value = item.sample_value;
      cls_cmd.sample_time  = item.sample_time;
    end
  end

  // The held request moves on whenever the queue has room.
  assign push       = held && !qstat.full;
  assign push_cmd   = held_cmd;
  assign item_ready = !held || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_valid && item_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_cmd <= cls_cmd;
    end
  end

endmodule

>>> hdl/sraa_queue.sv
// Short first-in first-out queue of classified requests between front and back.
// Depends on sraa_pkg.
module sraa_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sraa_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output sraa_pkg::cmd_t    head,
  output sraa_pkg::qstat_t  qstat
);

  sraa_pkg::cmd_t                      slots [sraa_pkg::QUEUE_DEPTH];
  logic [sraa_pkg::QPTR_W-1:0]         wr_ptr;
  logic [sraa_pkg::QPTR_W-1:0]         rd_ptr;
  logic [sraa_pkg::QCNT_W-1:0]         count;

  localparam logic [sraa_pkg::QPTR_W-1:0] LastPtr = sraa_pkg::QPTR_W'(sraa_pkg::QUEUE_DEPTH - 1);
  localparam logic [sraa_pkg::QCNT_W-1:0] Depth   = sraa_pkg::QCNT_W'(sraa_pkg::QUEUE_DEPTH);

  assign qstat.full  = (count == Depth);
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> hdl/sraa_back.sv
// Back stage: table search, window update, average by reciprocal divide, alarm flags
// and the result register. Depends on sraa_pkg.
module sraa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [15:0]  hot_limit,
  input  logic signed [15:0]  cold_limit,
  input  sraa_pkg::qstat_t    qstat,
  input  sraa_pkg::cmd_t      head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output sraa_pkg::result_t   result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_ENC  = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_ABS  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_QUO  = 4'd7;
  localparam logic [3:0] S_QD   = 4'd8;
  localparam logic [3:0] S_REM  = 4'd9;
  localparam logic [3:0] S_COR  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [sraa_pkg::USED_W-1:0] TableSize =
    sraa_pkg::USED_W'(sraa_pkg::TABLE_ENTRIES);
  localparam logic [sraa_pkg::FILL_W-1:0] WinLen = sraa_pkg::FILL_W'(sraa_pkg::AVG_LEN);

  logic [3:0]                         state;
  logic [3:0]                         state_next;
  sraa_pkg::cmd_t                     cmd;
  logic [sraa_pkg::USED_W-1:0]        used;
  logic [15:0]                        entry_sensor [sraa_pkg::TABLE_ENTRIES];
  logic [sraa_pkg::TABLE_ENTRIES-1:0] match_vec;
  logic [sraa_pkg::IDX_W-1:0]         idx;
  sraa_pkg::row_t                     rows [sraa_pkg::TABLE_ENTRIES];
  sraa_pkg::row_t                     rd_row;
  logic signed [sraa_pkg::SUM_W-1:0]  sum;
  logic [sraa_pkg::FILL_W-1:0]        div;
  logic                               neg;
  logic [sraa_pkg::MAG_W-1:0]         mag;
  logic [sraa_pkg::PROD_W-1:0]        prod;
  logic [sraa_pkg::MAG_W-1:0]         quo;
  logic [sraa_pkg::MAG_W-1:0]         qd;
  logic [sraa_pkg::MAG_W-1:0]         rem;
  sraa_pkg::result_t                  res;

  logic                               hit;
  logic [sraa_pkg::IDX_W-1:0]         first;
  sraa_pkg::row_t                     new_row;
  logic signed [sraa_pkg::SUM_W-1:0]  new_sum;
  logic [sraa_pkg::FILL_W-1:0]        new_div;
  logic                               mem_we;
  logic [sraa_pkg::IDX_W-1:0]         mem_waddr;
  sraa_pkg::row_t                     mem_wdata;
  logic [sraa_pkg::MAG_W-1:0]         signed_quo;
  logic signed [15:0]                 avg;
  logic                               out_free;
  logic [sraa_pkg::MAG_W-1:0]         div_ext;
  sraa_pkg::result_t                  load_res;
  sraa_pkg::result_t                  miss_res;
  sraa_pkg::result_t                  meas_res;

  assign out_free = !result_valid || result_ready;
  assign pop      = (state == S_IDLE) && !qstat.empty;
  assign div_ext  = sraa_pkg::MAG_W'(div);

  // First matching entry in the registered match vector.
  always_comb begin
    hit   = 1'b0;
    first = '0;
    for (int i = sraa_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit   = 1'b1;
        first = sraa_pkg::IDX_W'(i);
      end
    end
  end

  // Window update and sum for the row just read.
  always_comb begin
    new_row = rd_row;
    new_sum = '0;
    if (rd_row.fill < WinLen) begin
      new_row.samples[rd_row.fill] = cmd.sample_value;
      new_row.fill                 = rd_row.fill + 1'b1;
    end else begin
      new_row.full       = 1'b1;
      new_row.samples[0] = cmd.sample_value;
      new_row.fill       = sraa_pkg::FILL_W'(1);
    end
    for (int k = 0; k < sraa_pkg::AVG_LEN; k++) begin
      new_sum = new_sum + sraa_pkg::SUM_W'($signed(new_row.samples[k]));
    end
    new_div = new_row.full ? WinLen : new_row.fill;
  end

  // Single write port of the row memory: a load clears a row, a sample rewrites one.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = new_row;
    if (state == S_LOAD && used != TableSize) begin
      mem_we         = 1'b1;
      mem_waddr      = used[sraa_pkg::IDX_W-1:0];
      mem_wdata      = '0;
      mem_wdata.room = cmd.room_id;
    end else if (state == S_UPD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rows[mem_waddr] <= mem_wdata;
    end
    if (state == S_ENC) begin
      rd_row <= rows[first];
    end
  end

  // Signed average from the corrected quotient.
  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign avg        = signed_quo[15:0];

  // Result words for a load, an unknown sensor and a finished measurement.
  always_comb begin
    load_res          = '0;
    load_res.status   = (used == TableSize) ? sraa_pkg::ST_FULL : sraa_pkg::ST_LOADED;
    miss_res          = '0;
    miss_res.status   = sraa_pkg::ST_UNKNOWN;
    miss_res.time_out = cmd.sample_time;
    meas_res.status   = sraa_pkg::ST_MEASURED;
    meas_res.room_out = rd_row.room;
    meas_res.average  = avg;
    meas_res.hot      = (avg > hot_limit);
    meas_res.cold     = (avg < cold_limit);
    meas_res.time_out = cmd.sample_time;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!qstat.empty) state_next = (head.op == sraa_pkg::REQ_LOAD) ? S_LOAD : S_CMP;
      S_LOAD:  state_next = S_OUT;
      S_CMP:   state_next = S_ENC;
      S_ENC:   state_next = hit ? S_UPD : S_OUT;
      S_UPD:   state_next = S_ABS;
      S_ABS:   state_next = S_MUL;
      S_MUL:   state_next = S_QUO;
      S_QUO:   state_next = S_QD;
      S_QD:    state_next = S_REM;
      S_REM:   state_next = S_COR;
      S_COR:   if (rem < div_ext) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control state: sequencer, table occupancy and the output register's valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD && used != TableSize) begin
        used <= used + 1'b1;
      end
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Sensor ids sit in flip-flops so that all of them are compared at once.
  always_ff @(posedge clk) begin
    if (state == S_LOAD && used != TableSize) begin
      entry_sensor[used[sraa_pkg::IDX_W-1:0]] <= cmd.sensor;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd <= head;
      end
      S_LOAD: begin
        res <= load_res;
      end
      S_CMP: begin
        for (int i = 0; i < sraa_pkg::TABLE_ENTRIES; i++) begin
          match_vec[i] <= (sraa_pkg::USED_W'(i) < used) && (entry_sensor[i] == cmd.sensor);
        end
      end
      S_ENC: begin
        idx <= first;
        res <= miss_res;
      end
      S_UPD: begin
        sum <= new_sum;
        div <= new_div;
      end
      S_ABS: begin
        neg <= sum[sraa_pkg::SUM_W-1];
        mag <= sum[sraa_pkg::SUM_W-1] ? sraa_pkg::MAG_W'(-sum) : sraa_pkg::MAG_W'(sum);
      end
      S_MUL: begin
        prod <= sraa_pkg::PROD_W'(mag) * sraa_pkg::PROD_W'(sraa_pkg::recip(5'(div)));
      end
      S_QUO: begin
        quo <= prod[sraa_pkg::RECIP_SHIFT +: sraa_pkg::MAG_W];
      end
      S_QD: begin
        qd <= quo * div_ext;
      end
      S_REM: begin
        rem <= mag - qd;
      end
      S_COR: begin
        // The estimate never exceeds the true quotient; step up while a divisor remains.
        if (rem >= div_ext) begin
          quo <= quo + 1'b1;
          rem <= rem - div_ext;
        end else begin
          res <= meas_res;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result <= res;
    end
  end

endmodule

>>> hdl/sensor_running_average_alarm.sv
// Top level of the sensor running average alarm: configuration registers and the
// front, queue and back stages. Depends on sraa_pkg, sraa_front, sraa_queue, sraa_back.
//
// Each request gives exactly one result. For a measurement the back stage compares the id
// against all table entries, picks the first match (an unknown sensor ends there), reads
// the row memory, forms the window sum, then does a reciprocal multiply whose quotient
// needs at most one correction step with a five-sample window. The back stage handles one
// request at a time; the front stage and a two-entry queue keep taking requests while it
// works or while a result waits to be taken. The user must write limits through the
// configuration port only while idle; the block does not enforce this.
module sensor_running_average_alarm (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sraa_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_ready,
  output sraa_pkg::result_t  result,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic signed [15:0] hot_limit;
  logic signed [15:0] cold_limit;
  sraa_pkg::qstat_t   qstat;
  sraa_pkg::cmd_t     push_cmd;
  sraa_pkg::cmd_t     head;
  logic               push;
  logic               pop;

  // Alarm limits.
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_limit  <= sraa_pkg::HOT_RESET;
      cold_limit <= sraa_pkg::COLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sraa_pkg::REG_HOT:  hot_limit  <= cfg_data;
        sraa_pkg::REG_COLD: cold_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sraa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  sraa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  sraa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .hot_limit    (hot_limit),
    .cold_limit   (cold_limit),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> hdl/sraa_checker.sv
// Port-level checks of the sensor running average alarm, bound to its top level.
// Depends on sraa_pkg and sensor_running_average_alarm.
module sraa_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               result_valid,
  input  logic               result_ready,
  input  sraa_pkg::result_t  result
);

  // A result waiting to be taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // No result leaves straight after reset.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Only a measured request carries room, average and flags.
  a_unmeasured: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != sraa_pkg::ST_MEASURED |->
      result.room_out == 16'd0 && result.average == 16'sd0 && !result.hot && !result.cold)
    else $error("unmeasured result carries data");

  // Load results carry no timestamp.
  a_load_time: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == sraa_pkg::ST_LOADED ||
                     result.status == sraa_pkg::ST_FULL) |-> result.time_out == 32'd0)
    else $error("load result carries a timestamp");

endmodule

bind sensor_running_average_alarm sraa_checker u_sraa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

>>> tb/tb_sensor_running_average_alarm.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_running_average_alarm: directed table, then random phases.
// Depends on sraa_pkg and the block's RTL only.
module tb_sensor_running_average_alarm;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 285;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  sraa_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  sraa_pkg::result_t result;
  logic              cfg_write;
  logic              cfg_index;
  logic [15:0]       cfg_data;

  sensor_running_average_alarm i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the sensor table and the alarm limits.
  logic [15:0]        tab_sensor [sraa_pkg::TABLE_ENTRIES];
  logic [15:0]        tab_room   [sraa_pkg::TABLE_ENTRIES];
  logic signed [15:0] tab_window [sraa_pkg::TABLE_ENTRIES][sraa_pkg::AVG_LEN];
  int                 tab_fill   [sraa_pkg::TABLE_ENTRIES];
  bit                 tab_wrapped[sraa_pkg::TABLE_ENTRIES];
  int                 tab_used = 0;
  int                 lim_hot  = sraa_pkg::HOT_RESET;
  int                 lim_cold = sraa_pkg::COLD_RESET;

  // Readings still owed by the block, oldest first.
  sraa_pkg::result_t readings_due[$];

  // One row of the directed table; reps of zero means load until the table is full.
  typedef struct {
    sraa_pkg::item_t   req;
    int                reps;
    bit                typed;
    sraa_pkg::result_t want;
  } probe_t;
  probe_t probes[$];

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int error_count  = 0;
  int checked      = 0;
  int status_seen[4];
  int hot_seen     = 0;
  int cold_seen    = 0;
  int limit_writes = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic sraa_pkg::item_t mk_item(input logic kind, input logic [15:0] sid,
                                              input logic [15:0] rid, input logic [15:0] val,
                                              input logic [31:0] stamp);
    sraa_pkg::item_t it;
    it.req_type     = kind;
    it.sensor       = sid;
    it.room_id      = rid;
    it.sample_value = val;
    it.sample_time  = stamp;
    return it;
  endfunction

  function automatic sraa_pkg::result_t mk_result(input logic [1:0] st,
                                                  input logic [15:0] room,
                                                  input logic [15:0] avg, input logic hot,
                                                  input logic cold, input logic [31:0] stamp);
    sraa_pkg::result_t r;
    r.status   = st;
    r.room_out = room;
    r.average  = avg;
    r.hot      = hot;
    r.cold     = cold;
    r.time_out = stamp;
    return r;
  endfunction

  function automatic void add_probe(input sraa_pkg::item_t req, input int reps,
                                    input bit typed, input sraa_pkg::result_t want);
    probe_t pr;
    pr.req   = req;
    pr.reps  = reps;
    pr.typed = typed;
    pr.want  = want;
    probes.push_back(pr);
  endfunction

  function automatic string show_result(input sraa_pkg::result_t r);
    return $sformatf("status=%0d room=%h avg=%0d hot=%0b cold=%0b time=%h",
                     r.status, r.room_out, r.average, r.hot, r.cold, r.time_out);
  endfunction

  // Works out the reading for one request and updates the shadow table.
  function automatic sraa_pkg::result_t compute_reading(input sraa_pkg::item_t req);
    sraa_pkg::result_t r;
    int                slot;
    int                total;
    int                divisor;
    int                mean;
    int                k;
    r = '0;
    if (req.req_type == sraa_pkg::REQ_LOAD) begin
      if (tab_used >= sraa_pkg::TABLE_ENTRIES) begin
        r.status = sraa_pkg::ST_FULL;
      end else begin
        tab_sensor[tab_used] = req.sensor;
        tab_room[tab_used]   = req.room_id;
        for (k = 0; k < sraa_pkg::AVG_LEN; k++) tab_window[tab_used][k] = '0;
        tab_fill[tab_used]    = 0;
        tab_wrapped[tab_used] = 1'b0;
        tab_used++;
        r.status = sraa_pkg::ST_LOADED;
      end
      return r;
    end
    r.time_out = req.sample_time;
    slot = -1;
    for (k = 0; k < tab_used; k++) begin
      if (tab_sensor[k] == req.sensor) begin
        slot = k;
        break;
      end
    end
    if (slot < 0) begin
      r.status = sraa_pkg::ST_UNKNOWN;
      return r;
    end
    // The window wraps back to slot 0 once every slot has been written.
    if (tab_fill[slot] < sraa_pkg::AVG_LEN) begin
      tab_window[slot][tab_fill[slot]] = req.sample_value;
      tab_fill[slot]++;
    end else begin
      tab_wrapped[slot]   = 1'b1;
      tab_window[slot][0] = req.sample_value;
      tab_fill[slot]      = 1;
    end
    total = 0;
    for (k = 0; k < sraa_pkg::AVG_LEN; k++) total += tab_window[slot][k];
    divisor = tab_wrapped[slot] ? sraa_pkg::AVG_LEN : tab_fill[slot];
    if (divisor < 1) divisor = 1;
    mean = total / divisor;
    r.status   = sraa_pkg::ST_MEASURED;
    r.room_out = tab_room[slot];
    r.average  = 16'(mean);
    r.hot      = (mean > lim_hot);
    r.cold     = (mean < lim_cold);
    return r;
  endfunction

  // Presents one request from a falling edge and holds it until it is accepted.
  task automatic send_request(input sraa_pkg::item_t req, input bit typed,
                              input sraa_pkg::result_t want);
    sraa_pkg::result_t got;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    item       = req;
    item_valid = 1'b1;
    do @(posedge clk); while (item_ready !== 1'b1);
    got = compute_reading(req);
    if (typed) got = want;
    readings_due.push_back(got);
    status_seen[got.status]++;
    hot_seen  += got.hot;
    cold_seen += got.cold;
    @(negedge clk);
  endtask

  // Waits until every owed reading has come back, then lets the block settle.
  task automatic wait_for_readings();
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic signed [15:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == sraa_pkg::REG_HOT) lim_hot = value;
    else lim_cold = value;
    limit_writes++;
  endtask

  // Result side: random bursts of back-pressure.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        result_ready = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // Compare each reading with the oldest one owed.
  always @(posedge clk) begin : check_readings
    sraa_pkg::result_t want;
    if (!rst && result_valid === 1'b1 && result_ready === 1'b1) begin
      checked++;
      if (readings_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected reading %s", show_result(result));
      end else begin
        want = readings_due.pop_front();
        if (result.status !== want.status || result.room_out !== want.room_out ||
            result.average !== want.average || result.hot !== want.hot ||
            result.cold !== want.cold || result.time_out !== want.time_out) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: reading mismatch\n  expected %s\n  actual   %s",
                     show_result(want), show_result(result));
        end
      end
    end
  end

  // Watchdog: ends the run if no request or reading moves for too long.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d readings outstanding", readings_due.size());
        $display("sensor_running_average_alarm test failed");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    sraa_pkg::item_t req;
    int              k;
    int              n;
    int              ph;
    int              pick;
    int              centre;
    int              v;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_write  = 1'b0;
    cfg_index  = sraa_pkg::REG_HOT;
    cfg_data   = '0;

    // Directed table; limits are at their reset values throughout.
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h1234, 16'h0000, 16'h0000, 32'hFFFF_FFFF), 1, 1,
              mk_result(sraa_pkg::ST_UNKNOWN, 16'h0000, 16'h0000, 1'b0, 1'b0,
                        32'hFFFF_FFFF));
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'h0000, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF), 1, 1,
              mk_result(sraa_pkg::ST_LOADED, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'hFFFF, 16'h0000, 16'h8000, 32'h0), 1, 1,
              mk_result(sraa_pkg::ST_LOADED, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'hFFFF, 16'hFFFF, 16'h8000, 32'h0), 1, 1,
              mk_result(sraa_pkg::ST_MEASURED, 16'h0000, 16'h8000, 1'b0, 1'b1, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'hFFFF, 16'h0000, 16'h8000, 32'h1), 1, 1,
              mk_result(sraa_pkg::ST_MEASURED, 16'h0000, 16'h8000, 1'b0, 1'b1, 32'h1));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0000, 16'h0000, 16'h7FFF, 32'hFFFF_FFFF), 1, 1,
              mk_result(sraa_pkg::ST_MEASURED, 16'hFFFF, 16'h7FFF, 1'b1, 1'b0,
                        32'hFFFF_FFFF));
    // Fill the window, then wrap it.
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0000, 16'h0000, 16'h7FFF, 32'h0000_AAAA),
              4, 0, '0);
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0000, 16'h0000, 16'hFFFF, 32'h0000_5555),
              1, 0, '0);
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000),
              5, 0, '0);
    // A negative average truncates toward zero.
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'h0042, 16'h0777, 16'h0000, 32'h0), 1, 1,
              mk_result(sraa_pkg::ST_LOADED, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0042, 16'h0000, 16'hFFF9, 32'h10), 1, 0, '0);
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0042, 16'h0000, 16'h0000, 32'h11), 1, 0, '0);
    // Averages exactly on and just past each limit.
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'h0100, 16'h0101, 16'h0000, 32'h0), 1, 1,
              mk_result(sraa_pkg::ST_LOADED, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0100, 16'h0000, 16'd2500, 32'h20), 1, 1,
              mk_result(sraa_pkg::ST_MEASURED, 16'h0101, 16'd2500, 1'b0, 1'b0, 32'h20));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0100, 16'h0000, 16'd2502, 32'h21), 1, 0, '0);
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'h0200, 16'h0202, 16'h0000, 32'h0), 1, 1,
              mk_result(sraa_pkg::ST_LOADED, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0200, 16'h0000, 16'd1000, 32'h30), 1, 1,
              mk_result(sraa_pkg::ST_MEASURED, 16'h0202, 16'd1000, 1'b0, 1'b0, 32'h30));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'h0200, 16'h0000, 16'd998, 32'h31), 1, 0, '0);
    // A duplicate id is appended, but measurements keep going to the first match.
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'hFFFF, 16'h1234, 16'h0000, 32'h0), 1, 1,
              mk_result(sraa_pkg::ST_LOADED, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'hFFFF, 16'h0000, 16'd100, 32'h40), 1, 0, '0);
    add_probe(mk_item(sraa_pkg::REQ_MEAS, 16'hABCD, 16'h0000, 16'd100, 32'h41), 1, 1,
              mk_result(sraa_pkg::ST_UNKNOWN, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h41));
    // Load random entries until the table is full, then one load too many.
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'h0000, 16'h0000, 16'h0000, 32'h0), 0, 1,
              mk_result(sraa_pkg::ST_LOADED, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));
    add_probe(mk_item(sraa_pkg::REQ_LOAD, 16'h0000, 16'h0000, 16'h1111, 32'h1111), 1, 1,
              mk_result(sraa_pkg::ST_FULL, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0));

    repeat (9) @(negedge clk);
    rst = 1'b0;

    send_gap_pct = 25;
    stall_pct    = 6;
    foreach (probes[p]) begin
      n = (probes[p].reps == 0) ? sraa_pkg::TABLE_ENTRIES - tab_used : probes[p].reps;
      for (k = 0; k < n; k++) begin
        req = probes[p].req;
        if (probes[p].reps == 0) begin
          // A narrow id range makes duplicates likely.
          req.sensor  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'h5A00 + 16'($urandom_range(0, 15));
          req.room_id = 16'($urandom);
        end
        send_request(req, probes[p].typed, probes[p].want);
      end
    end
    item_valid = 1'b0;

    // Random phases, each under its own pair of limits; the last one runs without idling.
    for (ph = 0; ph < 4; ph++) begin
      wait_for_readings();
      case (ph)
        0: begin
          write_limit(sraa_pkg::REG_HOT, 16'($urandom));
          write_limit(sraa_pkg::REG_COLD, 16'($urandom));
          send_gap_pct = 30;
          stall_pct    = 8;
        end
        1: begin
          write_limit(sraa_pkg::REG_HOT, 16'sh7FFF);
          write_limit(sraa_pkg::REG_COLD, 16'sh8000);
          send_gap_pct = 10;
          stall_pct    = 3;
        end
        2: begin
          write_limit(sraa_pkg::REG_HOT, 16'sh8000);
          write_limit(sraa_pkg::REG_COLD, 16'sh7FFF);
          send_gap_pct = 50;
          stall_pct    = 15;
        end
        default: begin
          write_limit(sraa_pkg::REG_HOT, sraa_pkg::HOT_RESET);
          write_limit(sraa_pkg::REG_COLD, sraa_pkg::COLD_RESET);
          send_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase

      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        req  = mk_item(sraa_pkg::REQ_MEAS, 16'($urandom), 16'($urandom), 16'($urandom),
                       $urandom);
        if (pick >= 90) begin
          req.req_type = sraa_pkg::REQ_LOAD;
        end else if (pick < 78 && tab_used > 0) begin
          req.sensor = tab_sensor[$urandom_range(0, tab_used - 1)];
          // Most samples sit close to one of the limits so the flags toggle.
          if ($urandom_range(0, 4) != 0) begin
            centre = $urandom_range(0, 1) ? lim_hot : lim_cold;
            v = centre + int'($urandom_range(0, 40)) - 20;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            req.sample_value = 16'(v);
          end
        end
        send_request(req, 1'b0, '0);
      end
      item_valid = 1'b0;
    end

    wait_for_readings();
    $display("Checked %0d readings: %0d measured, %0d unknown, %0d loaded, %0d table full",
             checked, status_seen[sraa_pkg::ST_MEASURED], status_seen[sraa_pkg::ST_UNKNOWN],
             status_seen[sraa_pkg::ST_LOADED], status_seen[sraa_pkg::ST_FULL]);
    $display("%0d limit writes, %0d hot and %0d cold alarms, %0d mismatches",
             limit_writes, hot_seen, cold_seen, error_count);
    if (error_count == 0) begin
      $display("sensor_running_average_alarm test passed");
    end else begin
      $display("sensor_running_average_alarm test failed");
    end
    $finish;
  end

endmodule
